### sv/csvs_pkg.sv
package csvs_pkg;

    // Character codes
    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    // Default sizing
    localparam int FIELD_BYTES_DEF = 256;
    localparam int MAX_COLUMNS_DEF = 16;
    localparam int QUEUE_DEPTH     = 4;

    // Field counter width (limit register is 5 bits, so index never exceeds 31)
    localparam int FIELD_W = 5;
    localparam logic [FIELD_W-1:0] MAX_FIELDS_RESET = 5'd5;

    // Byte classes handed from front to back
    localparam logic [2:0] CLS_OTHER   = 3'd0;
    localparam logic [2:0] CLS_QUOTE   = 3'd1;
    localparam logic [2:0] CLS_COMMA   = 3'd2;
    localparam logic [2:0] CLS_BLANK   = 3'd3;
    localparam logic [2:0] CLS_ROW_END = 3'd4;

    // Scan modes
    localparam logic [1:0] MODE_PLAIN   = 2'd0;
    localparam logic [1:0] MODE_QUOTED  = 2'd1;
    localparam logic [1:0] MODE_AFTER   = 2'd2;
    localparam logic [1:0] MODE_PENDING = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_CHAR      = 2'd0;
    localparam logic [1:0] KIND_FIELD_END = 2'd1;
    localparam logic [1:0] KIND_ROW_END   = 2'd2;

    // Row status codes
    localparam logic [2:0] STAT_OK         = 3'd0;
    localparam logic [2:0] STAT_TOO_MANY   = 3'd1;
    localparam logic [2:0] STAT_UNTERM     = 3'd2;
    localparam logic [2:0] STAT_BAD_QUOTE  = 3'd3;
    localparam logic [2:0] STAT_TOO_LONG   = 3'd4;

    // Classified word in the queue
    typedef struct packed {
        logic [2:0] cls;
        logic [7:0] data_byte;
    } item_t;

    // Result word
    typedef struct packed {
        logic [1:0] result_kind;
        logic [3:0] col_index;
        logic [7:0] char_value;
        logic [2:0] row_status;
        logic [4:0] col_count;
    } result_t;

endpackage

### sv/csvs_front.sv
module csvs_front (
    input  logic [7:0]     data_byte,
    input  logic           row_end,
    output csvs_pkg::item_t item
);
    import csvs_pkg::*;

    logic is_blank;

    // Whitespace: space, tab through CR
    assign is_blank = (data_byte == CHAR_SPACE) ||
                      ((data_byte >= CHAR_TAB) && (data_byte <= CHAR_CR));

    // Classify the incoming word
    always_comb begin
        item.data_byte = data_byte;
        if (row_end) begin
            item.cls = CLS_ROW_END;
        end else if (data_byte == CHAR_QUOTE) begin
            item.cls = CLS_QUOTE;
        end else if (data_byte == CHAR_COMMA) begin
            item.cls = CLS_COMMA;
        end else if (is_blank) begin
            item.cls = CLS_BLANK;
        end else begin
            item.cls = CLS_OTHER;
        end
    end

endmodule

### sv/csvs_queue.sv
module csvs_queue #(
    parameter int DEPTH = csvs_pkg::QUEUE_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  csvs_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output csvs_pkg::item_t pop_item,
    output logic            empty
);
    import csvs_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t         mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### sv/csvs_back.sv
module csvs_back #(
    parameter int FIELD_BYTES = csvs_pkg::FIELD_BYTES_DEF,
    parameter int MAX_COLUMNS = csvs_pkg::MAX_COLUMNS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [csvs_pkg::FIELD_W-1:0]  col_limit,
    input  logic                          q_empty,
    input  csvs_pkg::item_t               q_item,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output csvs_pkg::result_t             out_result
);
    import csvs_pkg::*;

    localparam int CHW = $clog2(FIELD_BYTES);

    logic [1:0]         mode_reg,  mode_next;
    logic [FIELD_W-1:0] cur_reg,   cur_next;
    logic [CHW-1:0]     chars_reg, chars_next;
    logic [2:0]         err_reg,   err_next;
    logic               out_valid_reg, out_valid_next;
    result_t            result_reg, result_next;

    logic [FIELD_W-1:0] limit;
    logic [FIELD_W-1:0] cur_inc;
    logic [1:0]         mode_eff;
    logic               do_put;
    logic               do_end;
    logic               emit;
    logic [2:0]         row_stat;

    assign limit   = (int'(col_limit) > MAX_COLUMNS) ? FIELD_W'(MAX_COLUMNS) : col_limit;
    assign cur_inc = cur_reg + 1'b1;

    // Take a word when the output register is free or draining
    assign q_pop      = !q_empty && !(out_valid_reg && !out_ready);
    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

    // Per-word parse step
    always_comb begin
        mode_next  = mode_reg;
        cur_next   = cur_reg;
        chars_next = chars_reg;
        err_next   = err_reg;
        mode_eff   = mode_reg;
        do_put     = 1'b0;
        do_end     = 1'b0;
        emit       = 1'b0;
        row_stat   = err_reg;
        result_next = result_reg;

        if (q_pop) begin
            if (q_item.cls == CLS_ROW_END) begin
                // Row status and reset of the row state
                if (row_stat == STAT_OK && limit == '0) begin
                    row_stat = STAT_BAD_QUOTE;
                end
                if (row_stat == STAT_OK && mode_reg == MODE_QUOTED) begin
                    row_stat = STAT_UNTERM;
                end
                emit = 1'b1;
                result_next.result_kind = KIND_ROW_END;
                result_next.char_value  = '0;
                result_next.row_status  = row_stat;
                if (row_stat == STAT_OK) begin
                    result_next.col_index = cur_reg[3:0];
                    result_next.col_count = cur_inc;
                end else begin
                    result_next.col_index = '0;
                    result_next.col_count = '0;
                end
                mode_next  = MODE_PLAIN;
                cur_next   = '0;
                chars_next = '0;
                err_next   = STAT_OK;
            end else if (err_reg != STAT_OK) begin
                // drop until row end
            end else if (limit == '0) begin
                err_next = STAT_BAD_QUOTE;
            end else begin
                // Resolve a pending quote first
                if (mode_reg == MODE_PENDING) begin
                    if (q_item.cls == CLS_QUOTE) begin
                        mode_next = MODE_QUOTED;
                        do_put    = 1'b1;
                    end else begin
                        mode_next = MODE_AFTER;
                    end
                    mode_eff = (q_item.cls == CLS_QUOTE) ? MODE_PENDING : MODE_AFTER;
                end
                case (mode_eff)
                    MODE_PENDING: begin
                        // escaped quote handled above
                    end
                    MODE_QUOTED: begin
                        if (q_item.cls == CLS_QUOTE) begin
                            mode_next = MODE_PENDING;
                        end else begin
                            do_put = 1'b1;
                        end
                    end
                    MODE_AFTER: begin
                        if (q_item.cls == CLS_COMMA) begin
                            do_end = 1'b1;
                        end else if (q_item.cls != CLS_BLANK) begin
                            err_next = STAT_BAD_QUOTE;
                        end
                    end
                    default: begin
                        if (q_item.cls == CLS_COMMA) begin
                            do_end = 1'b1;
                        end else if (q_item.cls == CLS_QUOTE) begin
                            if (chars_reg != '0) begin
                                err_next = STAT_BAD_QUOTE;
                            end else begin
                                mode_next = MODE_QUOTED;
                            end
                        end else begin
                            do_put = 1'b1;
                        end
                    end
                endcase

                // Field character
                if (do_put) begin
                    if (chars_reg >= CHW'(FIELD_BYTES - 1)) begin
                        err_next = STAT_TOO_LONG;
                    end else begin
                        chars_next = chars_reg + 1'b1;
                        emit = 1'b1;
                        result_next.result_kind = KIND_CHAR;
                        result_next.col_index   = cur_reg[3:0];
                        result_next.char_value  = q_item.data_byte;
                        result_next.row_status  = STAT_OK;
                        result_next.col_count   = '0;
                    end
                end

                // Field end on comma
                if (do_end) begin
                    cur_next   = cur_inc;
                    chars_next = '0;
                    mode_next  = MODE_PLAIN;
                    if (cur_inc >= limit) begin
                        err_next = STAT_TOO_MANY;
                    end
                    emit = 1'b1;
                    result_next.result_kind = KIND_FIELD_END;
                    result_next.col_index   = cur_reg[3:0];
                    result_next.char_value  = '0;
                    result_next.row_status  = STAT_OK;
                    result_next.col_count   = '0;
                end
            end
        end

        out_valid_next = out_valid_reg && !out_ready;
        if (emit) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_PLAIN;
            cur_reg       <= '0;
            chars_reg     <= '0;
            err_reg       <= STAT_OK;
            out_valid_reg <= 1'b0;
        end else begin
            mode_reg      <= mode_next;
            cur_reg       <= cur_next;
            chars_reg     <= chars_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload, no reset
    always_ff @(posedge aclk) begin
        result_reg <= result_next;
    end

endmodule

### sv/csv_row_field_splitter_core.sv
// CSV row splitter: takes one row as a stream of bytes ending with a word that
// has s_tlast set (its byte is ignored), and returns one word per field
// character (unquoted, doubled quotes collapsed), one per comma as a field end,
// and one row-end word with status and field count; after the first error the
// rest of the row is dropped and only the row-end word reports it. A new byte
// is taken every cycle while the queue is not full; results pass through the
// classifier queue and then the output register of the parse stage, and
// the queue lets the input keep flowing while the output side stalls until it
// fills. cfg_wr_en/cfg_wr_data set the field limit (reset 5) and must only be
// written while the block is idle.
module csv_row_field_splitter_core #(
    parameter int FIELD_BYTES = csvs_pkg::FIELD_BYTES_DEF,
    parameter int MAX_COLUMNS = csvs_pkg::MAX_COLUMNS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,   // col_limit
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] data_byte
    input  logic        s_tlast,       // row_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,       // [3:0] col_index, [11:4] char_value,
                                       // [14:12] row_status, [19:15] col_count
    output logic [1:0]  m_tuser        // result_kind
);
    import csvs_pkg::*;

    logic [FIELD_W-1:0] col_limit_reg;
    item_t              in_item;
    item_t              q_item;
    logic               q_full;
    logic               q_empty;
    logic               q_pop;
    result_t            result;

    // Limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_limit_reg <= MAX_FIELDS_RESET;
        end else if (cfg_wr_en) begin
            col_limit_reg <= cfg_wr_data;
        end
    end

    assign s_tready = !q_full;

    csvs_front u_front (
        .data_byte (s_tdata),
        .row_end   (s_tlast),
        .item      (in_item)
    );

    csvs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_tvalid && !q_full),
        .push_item (in_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_item),
        .empty     (q_empty)
    );

    csvs_back #(
        .FIELD_BYTES (FIELD_BYTES),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .col_limit  (col_limit_reg),
        .q_empty    (q_empty),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    // Pack the result word
    assign m_tuser = result.result_kind;
    assign m_tdata = {4'b0, result.col_count, result.row_status,
                      result.char_value, result.col_index};

endmodule

### bench/tb_csv_row_field_splitter_core.sv
`timescale 1ns / 100ps

module tb_csv_row_field_splitter_core;
    import csvs_pkg::*;

    // One byte or terminator as handed to the sender
    typedef struct packed {
        logic [7:0] data_byte;
        logic       row_end;
    } row_item_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [4:0]  cfg_wr_data = 5'd0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = 8'd0;   // [7:0] data_byte
    logic        s_tlast     = 1'b0;   // row_end
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [23:0] m_tdata;              // [3:0] col_index, [11:4] char_value,
                                       // [14:12] row_status, [19:15] col_count
    logic [1:0]  m_tuser;              // result_kind

    csv_row_field_splitter_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Bytes waiting to be sent and results still owed by the block
    row_item_t feed_q[$];
    result_t   pending_results[$];
    int        items_queued = 0;
    int        err_count    = 0;
    int        gen_lim      = 5;

    // Row parser state as seen by the predictor
    logic [4:0] col_limit_q  = MAX_FIELDS_RESET;
    logic [1:0] scan_mode_q  = MODE_PLAIN;
    logic [4:0] field_no     = 5'd0;
    int         field_len    = 0;
    logic [2:0] row_err      = STAT_OK;

    function automatic int field_lim();
        return (col_limit_q > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : int'(col_limit_q);
    endfunction

    function automatic bit take_char(logic [7:0] b, output result_t r);
        r = '0;
        if (field_len >= FIELD_BYTES_DEF - 1) begin
            row_err = STAT_TOO_LONG;
            return 1'b0;
        end
        field_len++;
        r.result_kind = KIND_CHAR;
        r.col_index   = field_no[3:0];
        r.char_value  = b;
        return 1'b1;
    endfunction

    function automatic bit close_field(output result_t r);
        r = '0;
        r.result_kind = KIND_FIELD_END;
        r.col_index   = field_no[3:0];
        field_no++;
        if (field_no >= field_lim())
            row_err = STAT_TOO_MANY;
        field_len   = 0;
        scan_mode_q = MODE_PLAIN;
        return 1'b1;
    endfunction

    // Advance the row parser by one word; returns 1 when a result is due
    function automatic bit split_step(logic [7:0] b, logic row_end, output result_t r);
        logic [2:0] st;
        bit         blank;
        r     = '0;
        blank = (b == CHAR_SPACE) || (b >= CHAR_TAB && b <= CHAR_CR);
        if (row_end) begin
            st = row_err;
            if (st == STAT_OK && field_lim() == 0)
                st = STAT_BAD_QUOTE;
            if (st == STAT_OK && scan_mode_q == MODE_QUOTED)
                st = STAT_UNTERM;
            r.result_kind = KIND_ROW_END;
            if (st == STAT_OK) begin
                r.col_index = field_no[3:0];
                r.col_count = field_no + 5'd1;
            end else begin
                r.row_status = st;
            end
            scan_mode_q = MODE_PLAIN;
            field_no    = 5'd0;
            field_len   = 0;
            row_err     = STAT_OK;
            return 1'b1;
        end
        if (row_err != STAT_OK)
            return 1'b0;
        if (field_lim() == 0) begin
            row_err = STAT_BAD_QUOTE;
            return 1'b0;
        end
        // quote lookahead: doubled quote or close
        if (scan_mode_q == MODE_PENDING) begin
            if (b == CHAR_QUOTE) begin
                scan_mode_q = MODE_QUOTED;
                return take_char(b, r);
            end
            scan_mode_q = MODE_AFTER;
        end
        case (scan_mode_q)
            MODE_QUOTED: begin
                if (b == CHAR_QUOTE) begin
                    scan_mode_q = MODE_PENDING;
                    return 1'b0;
                end
                return take_char(b, r);
            end
            MODE_AFTER: begin
                if (b == CHAR_COMMA)
                    return close_field(r);
                if (!blank)
                    row_err = STAT_BAD_QUOTE;
                return 1'b0;
            end
            default: begin
                if (b == CHAR_COMMA)
                    return close_field(r);
                if (b == CHAR_QUOTE) begin
                    if (field_len != 0)
                        row_err = STAT_BAD_QUOTE;
                    else
                        scan_mode_q = MODE_QUOTED;
                    return 1'b0;
                end
                return take_char(b, r);
            end
        endcase
    endfunction

    // Mostly short gaps, some long ones, and idle-free stretches
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Sender
    row_item_t tx_item;
    result_t   pred_word;
    int        tx_gap  = 0;
    int        tx_calm = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid && split_step(s_tdata, s_tlast, pred_word))
                pending_results.push_back(pred_word);
            if (tx_gap > 0) begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end else if (feed_q.size() != 0) begin
                tx_item = feed_q.pop_front();
                s_tdata  <= tx_item.data_byte;
                s_tlast  <= tx_item.row_end;
                s_tvalid <= 1'b1;
                tx_gap = pick_gap(tx_calm);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    // Receiver: random stalls, compare each word with the oldest prediction
    result_t want_word;
    int      rx_stall = 0;
    int      rx_calm  = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual tuser=%0h tdata=%h",
                             $time, m_tuser, m_tdata);
                    err_count++;
                end else begin
                    want_word = pending_results.pop_front();
                    check_field("result_kind", want_word.result_kind, m_tuser);
                    check_field("col_index", want_word.col_index, m_tdata[3:0]);
                    check_field("char_value", want_word.char_value, m_tdata[11:4]);
                    check_field("row_status", want_word.row_status, m_tdata[14:12]);
                    check_field("col_count", want_word.col_count, m_tdata[19:15]);
                    check_field("tdata pad", 0, m_tdata[23:20]);
                end
            end
            if (rx_stall > 0) begin
                rx_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                rx_stall = pick_gap(rx_calm);
            end
        end
    end

    // Stimulus building blocks
    task automatic push_byte(logic [7:0] b);
        row_item_t it;
        it.data_byte = b;
        it.row_end   = 1'b0;
        feed_q.push_back(it);
        items_queued++;
    endtask

    task automatic push_end();
        row_item_t it;
        it.data_byte = 8'($urandom_range(0, 255));   // junk, must be ignored
        it.row_end   = 1'b1;
        feed_q.push_back(it);
        items_queued++;
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    function automatic logic [7:0] blank_byte();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CHAR_SPACE : 8'(9 + r);
    endfunction

    task automatic add_plain(int n);
        logic [7:0] b;
        for (int i = 0; i < n; i++) begin
            b = 8'($urandom_range(0, 255));
            if (b == CHAR_QUOTE || b == CHAR_COMMA)
                b = b ^ 8'h01;
            push_byte(b);
        end
    endtask

    // n unescaped characters; doubled quotes inside
    task automatic add_quoted(int n, bit closed);
        logic [7:0] b;
        int         r;
        push_byte(CHAR_QUOTE);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 9);
            if (r < 2)
                b = CHAR_QUOTE;
            else if (r < 3)
                b = CHAR_COMMA;
            else
                b = 8'($urandom_range(0, 255));
            push_byte(b);
            if (b == CHAR_QUOTE)
                push_byte(CHAR_QUOTE);
        end
        if (closed) begin
            push_byte(CHAR_QUOTE);
            r = $urandom_range(0, 3);
            for (int i = 0; i < r && r > 1; i++)
                push_byte(blank_byte());
        end
    endtask

    task automatic add_noise(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 6);
            case (r)
                0:       push_byte(CHAR_QUOTE);
                1:       push_byte(CHAR_COMMA);
                2:       push_byte(blank_byte());
                3:       push_byte(8'h00);
                4:       push_byte(8'hFF);
                default: push_byte(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    // A row mostly within the field limit, with a mix of field styles
    task automatic random_row();
        int nf;
        int r;
        int n;
        if ($urandom_range(0, 9) < 8)
            nf = $urandom_range(1, (gen_lim > 0) ? gen_lim : 1);
        else
            nf = gen_lim + $urandom_range(1, 3);
        for (int f = 0; f < nf; f++) begin
            if (f != 0)
                push_byte(CHAR_COMMA);
            r = $urandom_range(0, 99);
            n = $urandom_range(0, 5);
            if (r < 45)
                add_plain(n);
            else if (r < 82)
                add_quoted(n, 1'b1);
            else if (r < 92)
                add_noise(n + 1);
            else if (r < 96)
                add_quoted(n, 1'b0);
            else begin
                add_plain(n + 1);
                push_byte(CHAR_QUOTE);
            end
        end
        push_end();
    endtask

    task automatic wait_drained();
        while (feed_q.size() != 0 || s_tvalid || pending_results.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic random_rows(int target, bit pause_midway);
        int start;
        bit paused;
        start  = items_queued;
        paused = 1'b0;
        while (items_queued - start < target) begin
            random_row();
            // hold the sender until the block has answered everything
            if (pause_midway && !paused && items_queued - start >= target / 2) begin
                wait_drained();
                paused = 1'b1;
            end
        end
        wait_drained();
    endtask

    // Only called while the block is idle
    task automatic write_limit(logic [4:0] v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        col_limit_q  = v;
        gen_lim      = (v > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : int'(v);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed rows at the reset limit
        push_byte(8'h00);
        push_text(",\",\"\"\"\t,");
        push_byte(8'hFF);
        push_end();
        push_text("ab\"");
        push_end();
        push_text("\"a\"x");
        push_end();
        push_text("\"a");
        push_end();
        push_text("\"a\"");
        push_end();
        push_end();
        wait_drained();

        // widest limit; last legal character of a field, then one too many
        write_limit(5'd16);
        add_plain(FIELD_BYTES_DEF);
        push_byte(CHAR_COMMA);
        add_plain(2);
        push_end();
        random_rows(50, 1'b0);

        write_limit(5'd1);
        random_rows(30, 1'b0);

        // above the column count, clamps
        write_limit(5'd31);
        random_rows(50, 1'b1);

        // zero rejects every row
        write_limit(5'd0);
        random_rows(15, 1'b0);

        write_limit(5'($urandom_range(2, 15)));
        random_rows(40, 1'b0);

        write_limit(MAX_FIELDS_RESET);
        random_rows(40, 1'b0);

        if (err_count == 0)
            $display("[csv_row_field_splitter_core] OK");
        else
            $display("[csv_row_field_splitter_core] ERROR");
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("[csv_row_field_splitter_core] ERROR");
        $finish;
    end

endmodule

### csv_row_field_splitter_core.f
sv/csvs_pkg.sv
sv/csvs_front.sv
sv/csvs_queue.sv
sv/csvs_back.sv
sv/csv_row_field_splitter_core.sv
bench/tb_csv_row_field_splitter_core.sv
